@@ hdl/go_back_n_sender_core_assert.svh @@
// Assertion macros shared by the sender RTL.
`ifndef GO_BACK_N_SENDER_CORE_ASSERT_SVH
`define GO_BACK_N_SENDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GBN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gbn assertion failed");
`define GBN_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("gbn forbidden condition seen");
`else
`define GBN_ASSERT(lbl, prop)
`define GBN_NEVER(lbl, cond)
`endif
`endif

@@ hdl/gbn_pkg.sv @@
`default_nettype none
package gbn_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int MAX_WINDOW = 16;
  localparam int RUN_CNT_W  = $clog2(MAX_WINDOW + 1);

  localparam int DESC_DEPTH = 4;
  localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
  localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] LAST_SEQ_RST  = 16'd0;
  localparam logic [4:0]  WINDOW_RST    = 5'd6;
  localparam logic [3:0]  MAX_TRIES_RST = 4'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd3;

  typedef logic [SEQ_BITS:0] seq_t;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAST_SEQ    = 2'd0,
    CFG_WINDOW_SIZE = 2'd1,
    CFG_MAX_TRIES   = 2'd2,
    CFG_TIMEOUT     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] ack_number;
    logic        ack_is_terminal;
  } gbn_in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SEQ_BITS-1:0] seq_number;
    logic                is_resend;
    logic                last_of_run;
  } gbn_out_t;

  typedef struct packed {
    logic [15:0] last_seq;
    logic [4:0]  window_size;
    logic [3:0]  max_tries;
    logic [15:0] timeout_ticks;
  } gbn_cfg_t;

  // one run of results: cnt consecutive words starting at seq
  typedef struct packed {
    logic [1:0]           kind;
    logic [SEQ_BITS-1:0]  seq;
    logic [RUN_CNT_W-1:0] cnt;
    logic                 resend;
  } gbn_run_t;

endpackage
`default_nettype wire

@@ hdl/gbn_front.sv @@
`default_nettype none
`include "go_back_n_sender_core_assert.svh"
module gbn_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire gbn_pkg::gbn_in_t               in_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output gbn_pkg::gbn_run_t                   q_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import gbn_pkg::*;

  gbn_cfg_t    cfg_q;
  logic        active_q, active_d;
  seq_t        base_q, base_d;
  seq_t        next_q, next_d;
  logic [3:0]  tries_q, tries_d;
  logic [15:0] tick_q, tick_d;

  logic                 acc;
  logic                 fill;
  seq_t                 b, s, lim, endv, last1, ack_c;
  logic [RUN_CNT_W-1:0] w_eff, cnt;
  logic [15:0]          tick_n, tick_lim;
  logic                 rsnd;

  assign acc    = push_i && !q_full_i;
  assign last1  = {1'b0, cfg_q.last_seq} + seq_t'(1);
  assign tick_n = tick_q + 16'd1;
  assign tick_lim = (cfg_q.timeout_ticks == 16'd0) ? 16'd1 : cfg_q.timeout_ticks;
  assign ack_c  = (in_i.ack_number > cfg_q.last_seq) ? {1'b0, cfg_q.last_seq}
                                                     : {1'b0, in_i.ack_number};

  always_comb begin
    if (cfg_q.window_size == 5'd0) begin
      w_eff = RUN_CNT_W'(1);
    end else if (int'(cfg_q.window_size) > MAX_WINDOW) begin
      w_eff = RUN_CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = RUN_CNT_W'(cfg_q.window_size);
    end
  end

  always_comb begin
    active_d = active_q;
    base_d   = base_q;
    next_d   = next_q;
    tries_d  = tries_q;
    tick_d   = tick_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    fill     = 1'b0;
    rsnd     = 1'b0;
    b        = base_q;
    s        = next_q;
    lim      = '0;
    endv     = '0;
    cnt      = '0;

    if (acc) begin
      unique case (in_i.func)
        FUNC_START: begin
          active_d = 1'b1;
          b        = '0;
          s        = '0;
          tries_d  = '0;
          tick_d   = '0;
          fill     = 1'b1;
        end
        FUNC_ACK: begin
          if (active_q) begin
            if (in_i.ack_is_terminal) begin
              active_d = 1'b0;
              tick_d   = '0;
              tries_d  = '0;
              q_push_o = 1'b1;
              q_data_o.kind = KIND_DONE;
              q_data_o.cnt  = RUN_CNT_W'(1);
            end else if (ack_c >= base_q) begin
              b       = ack_c + seq_t'(1);
              s       = (next_q < b) ? b : next_q;
              tries_d = '0;
              tick_d  = '0;
              fill    = 1'b1;
            end
          end
        end
        FUNC_TICK: begin
          if (active_q) begin
            tick_d = tick_n;
            if (tick_n >= tick_lim) begin
              tick_d = '0;
              if (tries_q >= cfg_q.max_tries) begin
                active_d = 1'b0;
                tries_d  = '0;
                q_push_o = 1'b1;
                q_data_o.kind = KIND_FAIL;
                q_data_o.cnt  = RUN_CNT_W'(1);
              end else begin
                tries_d = tries_q + 4'd1;
                s       = base_q;
                rsnd    = 1'b1;
                fill    = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // window fill: sends run from s up to min(last_seq + 1, base + window)
    if (fill) begin
      lim  = b + seq_t'(w_eff);
      endv = (last1 < lim) ? last1 : lim;
      cnt  = (endv > s) ? RUN_CNT_W'(endv - s) : '0;
      base_d = b;
      next_d = (endv > s) ? endv : s;
      if (cnt != '0) begin
        q_push_o        = 1'b1;
        q_data_o.kind   = KIND_SEND;
        q_data_o.seq    = s[SEQ_BITS-1:0];
        q_data_o.cnt    = cnt;
        q_data_o.resend = rsnd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      base_q   <= '0;
      next_q   <= '0;
      tries_q  <= '0;
      tick_q   <= '0;
    end else begin
      active_q <= active_d;
      base_q   <= base_d;
      next_q   <= next_d;
      tries_q  <= tries_d;
      tick_q   <= tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.last_seq      <= LAST_SEQ_RST;
      cfg_q.window_size   <= WINDOW_RST;
      cfg_q.max_tries     <= MAX_TRIES_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LAST_SEQ:    cfg_q.last_seq      <= cfg_wdata_i[15:0];
        CFG_WINDOW_SIZE: cfg_q.window_size   <= cfg_wdata_i[4:0];
        CFG_MAX_TRIES:   cfg_q.max_tries     <= cfg_wdata_i[3:0];
        CFG_TIMEOUT:     cfg_q.timeout_ticks <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // next never falls behind base and never runs past a full window
  `GBN_ASSERT(a_next_ge_base, active_q |-> (next_q >= base_q))
  `GBN_ASSERT(a_next_in_window,
              active_q |-> ({1'b0, next_q} <= ({1'b0, base_q} + (SEQ_BITS+2)'(MAX_WINDOW))))

endmodule
`default_nettype wire

@@ hdl/gbn_fifo.sv @@
`default_nettype none
`include "go_back_n_sender_core_assert.svh"
module gbn_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire gbn_pkg::gbn_run_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output gbn_pkg::gbn_run_t      data_o,
  output logic                   empty_o
);
  import gbn_pkg::*;

  gbn_run_t                mem_q [DESC_DEPTH];
  logic [DESC_PTR_W-1:0]   wr_q, rd_q;
  logic [DESC_CNT_W-1:0]   cnt_q;

  function automatic logic [DESC_PTR_W-1:0] inc(input logic [DESC_PTR_W-1:0] p);
    return (p == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : p + DESC_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == DESC_CNT_W'(DESC_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + DESC_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - DESC_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `GBN_NEVER(a_no_overflow, push_i && full_o)
  `GBN_NEVER(a_no_underflow, pop_i && empty_o)

endmodule
`default_nettype wire

@@ hdl/gbn_back.sv @@
`default_nettype none
`include "go_back_n_sender_core_assert.svh"
module gbn_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire gbn_pkg::gbn_run_t q_data_i,
  output logic                   q_pop_o,
  output gbn_pkg::gbn_out_t      out_o,
  output logic                   empty_o,
  input  wire logic              pop_i
);
  import gbn_pkg::*;

  gbn_run_t cur_q;
  logic     cur_valid_q;
  gbn_out_t out_q;
  logic     out_valid_q;
  logic     advance, cur_last;

  // output slot frees up in the same cycle it is popped
  assign advance  = cur_valid_q && (!out_valid_q || pop_i);
  assign cur_last = (cur_q.cnt == RUN_CNT_W'(1));
  assign q_pop_o  = !q_empty_i && (!cur_valid_q || (advance && cur_last));
  assign out_o    = out_q;
  assign empty_o  = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (advance && cur_last) begin
        cur_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end else if (advance) begin
      cur_q.cnt <= cur_q.cnt - RUN_CNT_W'(1);
      cur_q.seq <= cur_q.seq + SEQ_BITS'(1);
    end
    if (advance) begin
      out_q.kind        <= cur_q.kind;
      out_q.seq_number  <= cur_q.seq;
      out_q.is_resend   <= cur_q.resend;
      out_q.last_of_run <= cur_last;
    end
  end

  `GBN_ASSERT(a_run_nonempty, cur_valid_q |-> (cur_q.cnt != '0))

endmodule
`default_nettype wire

@@ hdl/go_back_n_sender_core.sv @@
// Go-Back-N sender window control.
// Events enter through a queue-style port: in_i is taken when push_i is high
// and full_o is low. Results leave the same way: out_o holds the oldest word
// while empty_o is low and is taken when pop_i is high.
// Configuration (last_seq, window_size, max_tries, timeout_ticks) is written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// The front updates the window state in the cycle an event is accepted and
// queues at most one run of results (a send burst, done or fail); the front
// takes one event per cycle while the 4-run queue has room.
// The back expands each run into the output register, one word per cycle while
// the receiver keeps taking words; an event's run passes through the run
// queue, the current-run register and the output register, and a run holds at
// most a full 16-packet window.
// Reset clears the window state and queues and loads the register defaults
// (0, 6, 10, 3). When the receiver holds pop_i low the output word stays,
// the back stops, the run queue fills and full_o stalls the event source.
`default_nettype none
module go_back_n_sender_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire gbn_pkg::gbn_in_t               in_i,
  output logic                                full_o,
  output gbn_pkg::gbn_out_t                   out_o,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import gbn_pkg::*;

  logic     q_push, q_pop, q_full, q_empty;
  gbn_run_t q_wdata, q_rdata;

  assign full_o = q_full;

  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  gbn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  gbn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o),
    .empty_o   (empty_o),
    .pop_i     (pop_i)
  );

endmodule
`default_nettype wire
